// ===== rtl/core/fhd_pkg.sv =====
// ---------------------------------------------------------------------------
// fhd_pkg: shared types and constants for the frame header deframer
// Transaction payload types, result kinds, error codes, header layout and
// register map of the deframer core.
// ---------------------------------------------------------------------------
package fhd_pkg;

   // counter width default for the payload byte counter
   localparam int PAYLOAD_COUNT_BITS_DEF = 24;

   // header layout
   localparam int HEADER_BYTES = 24;
   localparam int MAGIC_BYTES  = 4;
   localparam int FIELD_BITS   = (HEADER_BYTES - MAGIC_BYTES) * 8;

   // register map (word index)
   localparam logic [1:0] REG_FRAME_VERSION = 2'd0;
   localparam logic [1:0] REG_MAX_PAYLOAD   = 2'd1;
   localparam logic [1:0] REG_TYPE_LOW      = 2'd2;
   localparam logic [1:0] REG_TYPE_HIGH     = 2'd3;

   // register reset values
   localparam logic [15:0] FRAME_VERSION_RST = 16'd1;
   localparam logic [23:0] MAX_PAYLOAD_RST   = 24'd1048576;
   localparam logic [15:0] TYPE_LOW_RST      = 16'd1;
   localparam logic [15:0] TYPE_HIGH_RST     = 16'd20;

   // input commands
   localparam logic CMD_DATA  = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   // result kinds
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // error codes
   localparam logic [1:0] ERR_BAD_MAGIC   = 2'd0;
   localparam logic [1:0] ERR_BAD_VERSION = 2'd1;
   localparam logic [1:0] ERR_BAD_TYPE    = 2'd2;
   localparam logic [1:0] ERR_TOO_LARGE   = 2'd3;

   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
   } fhd_req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  error_code;
      logic [15:0] message_type;
      logic [31:0] frame_flags;
      logic [63:0] request_tag;
      logic [23:0] frame_length;
      logic [7:0]  payload_byte;
      logic        end_of_frame;
   } fhd_rsp_type;

   // expected magic byte at a given header position
   function automatic logic [7:0] magic_byte(input logic [1:0] pos);
      logic [7:0] value;
      unique case (pos)
         2'd0: value = 8'h43;
         2'd1: value = 8'h44;
         2'd2: value = 8'h53;
         2'd3: value = 8'h4B;
         default: value = 8'h00;
      endcase
      return value;
   endfunction

endpackage

// ===== rtl/core/frame_header_deframer_core.sv =====
// ---------------------------------------------------------------------------
// frame_header_deframer_core: length-prefixed frame deframer
// Parses 24-byte big-endian headers from a byte stream, checks them and
// passes the payload bytes through with the last one marked.
// ---------------------------------------------------------------------------
// The core takes one stream byte per clock cycle while req_stall is low, with
// no gaps of its own. Each accepted transaction updates the parse state in the
// same cycle, and a result, when there is one, is registered and shows on the
// rsp_ channel from the output register. A one-entry skid register behind the
// output register lets input continue while a result waits; req_stall rises
// only while that skid entry is occupied, so input keeps flowing while only
// the output register is stalled and pauses while the skid entry drains.
// Header bytes only shift a header register or check a magic byte, and
// payload bytes only decrement a counter; the header checks on the last
// header byte are one equality and four magnitude compares. Registers are
// word-addressed at byte offsets 0, 4, 8 and 12 and should be written only
// while the core is idle.
module frame_header_deframer_core #(
   parameter int PAYLOAD_COUNT_BITS = fhd_pkg::PAYLOAD_COUNT_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   // input stream
   input  logic                req_valid,
   output logic                req_stall,
   input  fhd_pkg::fhd_req_type req_payload,
   // results
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output fhd_pkg::fhd_rsp_type rsp_payload,
   // register port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [3:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);
   import fhd_pkg::*;

   localparam int CB = PAYLOAD_COUNT_BITS;
   localparam logic [32:0] COUNT_MAX = (33'd1 << CB) - 33'd1;

   // configuration registers
   logic [15:0] frame_version_ff;
   logic [23:0] max_payload_ff;
   logic [15:0] type_low_ff;
   logic [15:0] type_high_ff;

   // parse state
   logic                  in_payload_ff, in_payload_in;
   logic [4:0]            header_count_ff, header_count_in;
   logic                  magic_ok_ff, magic_ok_in;
   logic [FIELD_BITS-1:0] hdr_ff, hdr_in;
   logic [CB-1:0]         payload_left_ff, payload_left_in;

   // output register and skid entry
   logic        out_valid_ff, out_valid_in;
   fhd_rsp_type out_ff, out_in;
   logic        skid_valid_ff, skid_valid_in;
   fhd_rsp_type skid_ff, skid_in;

   logic        accept;
   logic        pop;
   logic        has_rsp;
   fhd_rsp_type rsp_new;

   logic [FIELD_BITS-1:0] hdr_full;
   logic [15:0]           f_version;
   logic [15:0]           f_type;
   logic [31:0]           f_flags;
   logic [63:0]           f_request;
   logic [31:0]           f_length;

   assign pready    = 1'b1;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign pop       = out_valid_ff && !rsp_stall;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_version_ff <= FRAME_VERSION_RST;
         max_payload_ff   <= MAX_PAYLOAD_RST;
         type_low_ff      <= TYPE_LOW_RST;
         type_high_ff     <= TYPE_HIGH_RST;
      end else if (psel && penable && pwrite && pready) begin
         unique case (paddr[3:2])
            REG_FRAME_VERSION: frame_version_ff <= pwdata[15:0];
            REG_MAX_PAYLOAD:   max_payload_ff   <= pwdata[23:0];
            REG_TYPE_LOW:      type_low_ff      <= pwdata[15:0];
            REG_TYPE_HIGH:     type_high_ff     <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (paddr[3:2])
         REG_FRAME_VERSION: prdata = {16'd0, frame_version_ff};
         REG_MAX_PAYLOAD:   prdata = {8'd0, max_payload_ff};
         REG_TYPE_LOW:      prdata = {16'd0, type_low_ff};
         REG_TYPE_HIGH:     prdata = {16'd0, type_high_ff};
         default:           prdata = 32'd0;
      endcase
   end

   // header fields including the byte now arriving
   assign hdr_full  = {hdr_ff[FIELD_BITS-9:0], req_payload.data_byte};
   assign f_version = hdr_full[159:144];
   assign f_type    = hdr_full[143:128];
   assign f_flags   = hdr_full[127:96];
   assign f_request = hdr_full[95:32];
   assign f_length  = hdr_full[31:0];

   // parse step for one transaction
   always_comb begin
      in_payload_in   = in_payload_ff;
      header_count_in = header_count_ff;
      magic_ok_in     = magic_ok_ff;
      hdr_in          = hdr_ff;
      payload_left_in = payload_left_ff;
      has_rsp         = 1'b0;
      rsp_new         = '0;

      if (req_payload.command == CMD_FLUSH) begin
         in_payload_in   = 1'b0;
         header_count_in = 5'd0;
         magic_ok_in     = 1'b1;
         payload_left_in = '0;
      end else if (in_payload_ff) begin
         // payload pass-through
         has_rsp              = 1'b1;
         rsp_new.kind         = KIND_PAYLOAD;
         rsp_new.payload_byte = req_payload.data_byte;
         if (payload_left_ff <= CB'(1)) begin
            rsp_new.end_of_frame = 1'b1;
            in_payload_in        = 1'b0;
            payload_left_in      = '0;
         end else begin
            payload_left_in = payload_left_ff - CB'(1);
         end
      end else begin
         // header collection
         if (header_count_ff < 5'(MAGIC_BYTES)) begin
            if (req_payload.data_byte != magic_byte(header_count_ff[1:0])) begin
               magic_ok_in = 1'b0;
            end
         end else begin
            hdr_in = hdr_full;
         end

         if (header_count_ff != 5'(HEADER_BYTES - 1)) begin
            header_count_in = header_count_ff + 5'd1;
         end else begin
            // last header byte: check and emit
            has_rsp         = 1'b1;
            in_payload_in   = 1'b0;
            header_count_in = 5'd0;
            magic_ok_in     = 1'b1;
            payload_left_in = '0;
            rsp_new.kind    = KIND_ERROR;
            priority if (!magic_ok_ff) begin
               rsp_new.error_code = ERR_BAD_MAGIC;
            end else if (f_version != frame_version_ff) begin
               rsp_new.error_code = ERR_BAD_VERSION;
            end else if (f_type < type_low_ff || f_type > type_high_ff) begin
               rsp_new.error_code = ERR_BAD_TYPE;
            end else if (f_length > {8'd0, max_payload_ff} ||
                         {1'b0, f_length} > COUNT_MAX) begin
               rsp_new.error_code = ERR_TOO_LARGE;
            end else begin
               rsp_new.kind           = KIND_HEADER;
               rsp_new.message_type   = f_type;
               rsp_new.frame_flags    = f_flags;
               rsp_new.request_tag    = f_request;
               rsp_new.frame_length   = f_length[23:0];
               rsp_new.end_of_frame   = (f_length == 32'd0);
               in_payload_in          = (f_length != 32'd0);
               payload_left_in        = f_length[CB-1:0];
            end
         end
      end
   end

   // output register with one skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept && has_rsp) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            out_in       = rsp_new;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = rsp_new;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff   <= 1'b0;
         header_count_ff <= 5'd0;
         magic_ok_ff     <= 1'b1;
         payload_left_ff <= '0;
         out_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            in_payload_ff   <= in_payload_in;
            header_count_ff <= header_count_in;
            magic_ok_ff     <= magic_ok_in;
            payload_left_ff <= payload_left_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         hdr_ff <= hdr_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

// ===== sim/tb_frame_header_deframer_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_frame_header_deframer_core: self-checking bench for the frame deframer
// Streams byte transactions through the core and predicts every header,
// payload and error result from an internal parser model. Each observed
// result is checked field by field against the oldest prediction. Runs
// several register settings and idle patterns, including a long output hold.
// ---------------------------------------------------------------------------
module tb_frame_header_deframer_core;
   import fhd_pkg::*;

   localparam int          COUNT_BITS   = PAYLOAD_COUNT_BITS_DEF;
   localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 1;
   localparam bit [31:0]   MAGIC_WORD   = "CDSK";
   localparam int          HOLD_CYCLES  = 400;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          TIMEOUT_NS   = 3_000_000;

   typedef enum {
      TRAFFIC_NONE,
      TRAFFIC_SENDER,
      TRAFFIC_RECEIVER,
      TRAFFIC_BOTH,
      TRAFFIC_HOLD
   } traffic_mode_type;

   // dut signals
   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   fhd_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   fhd_rsp_type rsp_payload;
   logic        psel      = 1'b0;
   logic        penable   = 1'b0;
   logic        pwrite    = 1'b0;
   logic [3:0]  paddr     = '0;
   logic [31:0] pwdata    = '0;
   logic [31:0] prdata;
   logic        pready;

   // stimulus and expectation stores
   fhd_req_type      stream_bytes[$];
   fhd_rsp_type      expected_outputs[$];
   int               stream_byte_count = 0;
   int               mismatch_count = 0;
   traffic_mode_type traffic_mode = TRAFFIC_NONE;
   int               hold_cycles = 0;

   // register copy
   bit [15:0] cfg_version     = FRAME_VERSION_RST;
   bit [23:0] cfg_max_payload = MAX_PAYLOAD_RST;
   bit [15:0] cfg_type_low    = TYPE_LOW_RST;
   bit [15:0] cfg_type_high   = TYPE_HIGH_RST;

   // parser state copy
   bit                  in_payload;
   bit [4:0]            hdr_pos;
   bit                  magic_good;
   bit [15:0]           hdr_version_q;
   bit [15:0]           hdr_type_q;
   bit [31:0]           hdr_flags_q;
   bit [63:0]           hdr_tag_q;
   bit [31:0]           hdr_length_q;
   bit [COUNT_BITS-1:0] bytes_left;

   frame_header_deframer_core #(
      .PAYLOAD_COUNT_BITS(COUNT_BITS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always #5 clock = ~clock;

   // drop any partial header or payload
   function automatic void clear_parse();
      in_payload    = 1'b0;
      hdr_pos       = '0;
      magic_good    = 1'b1;
      hdr_version_q = '0;
      hdr_type_q    = '0;
      hdr_flags_q   = '0;
      hdr_tag_q     = '0;
      hdr_length_q  = '0;
      bytes_left    = '0;
   endfunction

   // advance the parser by one transaction, returns 1 when a result is due
   function automatic bit parse_stream_byte(input fhd_req_type item,
                                            output fhd_rsp_type result);
      bit [4:0]  pos;
      bit [7:0]  b;
      bit [31:0] frame_len;
      bit        accepted;
      pos    = hdr_pos;
      b      = item.data_byte;
      result = '0;
      if (item.command == CMD_FLUSH) begin
         clear_parse();
         return 1'b0;
      end
      // payload pass-through
      if (in_payload) begin
         result.kind         = KIND_PAYLOAD;
         result.payload_byte = b;
         if (bytes_left <= 1) begin
            result.end_of_frame = 1'b1;
            in_payload = 1'b0;
            bytes_left = '0;
         end else begin
            bytes_left = bytes_left - 1'b1;
         end
         return 1'b1;
      end
      // shift the header byte into its field
      if (pos < 4) begin
         if (b != MAGIC_WORD[31 - 8*pos -: 8]) magic_good = 1'b0;
      end else if (pos < 6) begin
         hdr_version_q = {hdr_version_q[7:0], b};
      end else if (pos < 8) begin
         hdr_type_q = {hdr_type_q[7:0], b};
      end else if (pos < 12) begin
         hdr_flags_q = {hdr_flags_q[23:0], b};
      end else if (pos < 20) begin
         hdr_tag_q = {hdr_tag_q[55:0], b};
      end else begin
         hdr_length_q = {hdr_length_q[23:0], b};
      end
      if (pos < HEADER_BYTES - 1) begin
         hdr_pos = pos + 1'b1;
         return 1'b0;
      end
      // last header byte: checks in priority order
      result.kind = KIND_ERROR;
      if (!magic_good) begin
         result.error_code = ERR_BAD_MAGIC;
      end else if (hdr_version_q != cfg_version) begin
         result.error_code = ERR_BAD_VERSION;
      end else if (hdr_type_q < cfg_type_low || hdr_type_q > cfg_type_high) begin
         result.error_code = ERR_BAD_TYPE;
      end else if (hdr_length_q > cfg_max_payload || hdr_length_q > COUNT_MAX) begin
         result.error_code = ERR_TOO_LARGE;
      end else begin
         result.kind           = KIND_HEADER;
         result.message_type   = hdr_type_q;
         result.frame_flags    = hdr_flags_q;
         result.request_tag    = hdr_tag_q;
         result.frame_length   = hdr_length_q[23:0];
         result.end_of_frame   = (hdr_length_q == 0);
      end
      frame_len = hdr_length_q;
      accepted  = (result.kind == KIND_HEADER);
      clear_parse();
      if (accepted && frame_len != 0) begin
         in_payload = 1'b1;
         bytes_left = frame_len[COUNT_BITS-1:0];
      end
      return 1'b1;
   endfunction

   function automatic bit sender_pauses();
      case (traffic_mode)
         TRAFFIC_SENDER: return $urandom_range(99) < 84;
         TRAFFIC_BOTH:   return $urandom_range(99) < 37;
         default:        return 1'b0;
      endcase
   endfunction

   // input driver: offer queued bytes, predict on each accepted transaction
   always @(posedge clock) begin
      fhd_req_type next_item;
      bit          next_valid;
      fhd_rsp_type predicted;
      if (reset) begin
         clear_parse();
         req_valid <= 1'b0;
      end else begin
         next_item  = req_payload;
         next_valid = req_valid;
         if (req_valid && !req_stall) begin
            if (parse_stream_byte(req_payload, predicted))
               expected_outputs.insert(expected_outputs.size(), predicted);
            next_valid = 1'b0;
         end
         if (!next_valid && stream_bytes.size() != 0 && !sender_pauses()) begin
            next_item  = stream_bytes.pop_front();
            next_valid = 1'b1;
         end
         req_valid   <= next_valid;
         req_payload <= next_item;
      end
   end

   // output stall: random per mode, or one long hold counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         hold_cycles <= 0;
      end else if (traffic_mode == TRAFFIC_HOLD && hold_cycles < HOLD_CYCLES) begin
         rsp_stall   <= 1'b1;
         hold_cycles <= hold_cycles + 1;
      end else begin
         if (traffic_mode != TRAFFIC_HOLD) hold_cycles <= 0;
         case (traffic_mode)
            TRAFFIC_RECEIVER: rsp_stall <= ($urandom_range(99) < 84);
            TRAFFIC_BOTH:     rsp_stall <= ($urandom_range(99) < 37);
            default:          rsp_stall <= 1'b0;
         endcase
      end
   end

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   // result monitor
   always @(posedge clock) begin
      fhd_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outputs.size() == 0) begin
            mismatch_count++;
            $display("%0t ns: unexpected result, expected none, actual %p",
                     $time, rsp_payload);
         end else begin
            want = expected_outputs.pop_front();
            check_field("kind", 64'(want.kind), 64'(rsp_payload.kind));
            check_field("error_code", 64'(want.error_code), 64'(rsp_payload.error_code));
            check_field("message_type", 64'(want.message_type),
                        64'(rsp_payload.message_type));
            check_field("frame_flags", 64'(want.frame_flags),
                        64'(rsp_payload.frame_flags));
            check_field("request_tag", want.request_tag, rsp_payload.request_tag);
            check_field("frame_length", 64'(want.frame_length),
                        64'(rsp_payload.frame_length));
            check_field("payload_byte", 64'(want.payload_byte),
                        64'(rsp_payload.payload_byte));
            check_field("end_of_frame", 64'(want.end_of_frame),
                        64'(rsp_payload.end_of_frame));
         end
      end
   end

   // register write: setup cycle then access cycle
   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (index)
         REG_FRAME_VERSION: cfg_version     = value[15:0];
         REG_MAX_PAYLOAD:   cfg_max_payload = value[23:0];
         REG_TYPE_LOW:      cfg_type_low    = value[15:0];
         REG_TYPE_HIGH:     cfg_type_high   = value[15:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic write_all(input logic [31:0] version, input logic [31:0] max_len,
                            input logic [31:0] type_lo, input logic [31:0] type_hi);
      write_register(REG_FRAME_VERSION, version);
      write_register(REG_MAX_PAYLOAD, max_len);
      write_register(REG_TYPE_LOW, type_lo);
      write_register(REG_TYPE_HIGH, type_hi);
   endtask

   function automatic void push_byte(input bit [7:0] value);
      fhd_req_type item;
      item.command   = CMD_DATA;
      item.data_byte = value;
      stream_bytes.insert(stream_bytes.size(), item);
      stream_byte_count++;
   endfunction

   // flush carries a random data byte that must be ignored
   function automatic void push_flush();
      fhd_req_type item;
      item.command   = CMD_FLUSH;
      item.data_byte = 8'($urandom);
      stream_bytes.insert(stream_bytes.size(), item);
      stream_byte_count++;
   endfunction

   // queue the first kept bytes of a frame, optionally with one magic byte corrupted
   function automatic void add_frame(input bit [15:0] version, input bit [15:0] msg_type,
                                     input bit [31:0] flags, input bit [63:0] tag,
                                     input bit [31:0] length, input int flip_pos,
                                     input int kept);
      bit [HEADER_BYTES*8-1:0] header;
      header = {MAGIC_WORD, version, msg_type, flags, tag, length};
      if (flip_pos >= 0)
         header[HEADER_BYTES*8-1 - 8*flip_pos -: 8] =
            header[HEADER_BYTES*8-1 - 8*flip_pos -: 8] ^ 8'($urandom_range(255, 1));
      for (int i = 0; i < kept; i++)
         push_byte(i < HEADER_BYTES ? header[HEADER_BYTES*8-1 - 8*i -: 8] : 8'($urandom));
   endfunction

   // mostly good frames, plus header errors, cut frames and stray bytes
   function automatic void add_random_frame();
      int unsigned pick;
      bit [15:0]   version;
      bit [15:0]   msg_type;
      bit [31:0]   length;
      int          flip_pos;
      int          full;
      bit          passes;
      pick     = $urandom_range(99);
      version  = cfg_version;
      flip_pos = -1;
      if (cfg_type_low <= cfg_type_high)
         msg_type = 16'(cfg_type_low + $urandom_range(cfg_type_high - cfg_type_low));
      else
         msg_type = 16'($urandom);
      case ($urandom_range(3))
         0, 1:    length = $urandom_range(8);
         2:       length = $urandom_range(40);
         default: length = (cfg_max_payload <= 64) ? cfg_max_payload : $urandom_range(64);
      endcase
      if (length > cfg_max_payload) length = cfg_max_payload;
      // stray bytes, then a flush to realign
      if (pick < 6) begin
         repeat ($urandom_range(30)) push_byte(8'($urandom));
         push_flush();
         return;
      end
      if (pick < 14) begin
         flip_pos = $urandom_range(3);
      end else if (pick < 20) begin
         version = version ^ 16'($urandom_range(65535, 1));
      end else if (pick < 26) begin
         if (cfg_type_low > 0 && (cfg_type_high == 16'hFFFF || $urandom_range(1) == 0))
            msg_type = 16'($urandom_range(cfg_type_low - 1));
         else if (cfg_type_high != 16'hFFFF)
            msg_type = 16'($urandom_range(16'hFFFF, cfg_type_high + 1));
      end else if (pick < 32) begin
         if (cfg_max_payload != 24'hFFFFFF && $urandom_range(1) == 0)
            length = cfg_max_payload + 32'($urandom_range(4, 1));
         else
            length = {8'($urandom_range(255, 1)), 24'($urandom)};
      end
      passes = flip_pos < 0 && version == cfg_version && msg_type >= cfg_type_low &&
               msg_type <= cfg_type_high && length <= cfg_max_payload;
      full = HEADER_BYTES + (passes ? int'(length) : 0);
      if (pick >= 32 && pick < 40) begin
         // cut short anywhere, then flushed
         add_frame(version, msg_type, $urandom, {$urandom, $urandom}, length, flip_pos,
                   $urandom_range(full - 1));
         push_flush();
      end else begin
         add_frame(version, msg_type, $urandom, {$urandom, $urandom}, length, flip_pos,
                   full);
      end
   endfunction

   function automatic void fill_random(input int count);
      int target;
      target = stream_byte_count + count;
      while (stream_byte_count < target) add_random_frame();
   endfunction

   // wait until every byte is taken and every result seen, then let the core settle
   task automatic wait_until_quiet();
      do @(negedge clock);
      while (stream_bytes.size() != 0 || req_valid || expected_outputs.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // run limit
   initial begin
      #(TIMEOUT_NS);
      $display("** frame_header_deframer_core: FAILED **");
      $finish;
   end

   // test sequence
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset register values, no idling, directed frames first
      traffic_mode = TRAFFIC_NONE;
      add_frame(16'd1, 16'd1, 32'h0, 64'h0, 32'd3, -1, HEADER_BYTES + 3);
      add_frame(16'd1, 16'd20, '1, '1, 32'd0, -1, HEADER_BYTES);
      // bad magic, next byte starts a fresh header
      add_frame(16'd1, 16'd5, $urandom, {$urandom, $urandom}, 32'd1, 0, HEADER_BYTES);
      add_frame(16'd1, 16'd5, $urandom, {$urandom, $urandom}, 32'd2, -1, HEADER_BYTES + 2);
      add_frame(16'd2, 16'd5, $urandom, {$urandom, $urandom}, 32'd1, -1, HEADER_BYTES);
      add_frame(16'd1, 16'd0, $urandom, {$urandom, $urandom}, 32'd1, -1, HEADER_BYTES);
      add_frame(16'd1, 16'd21, $urandom, {$urandom, $urandom}, 32'd1, -1, HEADER_BYTES);
      add_frame(16'd1, 16'd7, $urandom, {$urandom, $urandom}, 32'd1048577, -1,
                HEADER_BYTES);
      // every check fails at once: magic wins, then type over length
      add_frame(16'hFFFF, 16'hFFFF, '1, '1, '1, 3, HEADER_BYTES);
      add_frame(16'd1, 16'hFFFF, '1, '1, '1, -1, HEADER_BYTES);
      // largest length accepted, flushed inside the payload
      add_frame(16'd1, 16'd3, $urandom, {$urandom, $urandom}, 32'd1048576, -1,
                HEADER_BYTES + 6);
      push_flush();
      // flush inside the header, and flush while idle
      add_frame(16'd1, 16'd3, $urandom, {$urandom, $urandom}, 32'd5, -1, 10);
      push_flush();
      push_flush();
      add_frame(16'd1, 16'd2, $urandom, {$urandom, $urandom}, 32'd2, -1, HEADER_BYTES + 2);
      fill_random(130);
      wait_until_quiet();

      // all registers at zero, sender idling
      write_all(32'h0, 32'h0, 32'h0, 32'h0);
      traffic_mode = TRAFFIC_SENDER;
      fill_random(130);
      wait_until_quiet();

      // all registers at their top values, receiver stalling
      write_all(32'hFFFF, 32'hFF_FFFF, 32'hFFFF, 32'hFFFF);
      traffic_mode = TRAFFIC_RECEIVER;
      add_frame(16'hFFFF, 16'hFFFF, $urandom, {$urandom, $urandom}, 32'h00FF_FFFF, -1,
                HEADER_BYTES + 4);
      push_flush();
      // lengths beyond the counter width
      add_frame(16'hFFFF, 16'hFFFF, $urandom, {$urandom, $urandom}, 32'h0100_0000, -1,
                HEADER_BYTES);
      add_frame(16'hFFFF, 16'hFFFF, $urandom, {$urandom, $urandom}, 32'hFFFF_FFFF, -1,
                HEADER_BYTES);
      fill_random(130);
      wait_until_quiet();

      // empty type range, both sides idling
      write_all($urandom_range(16'hFFFF), 32'd5, 32'd200, 32'd100);
      traffic_mode = TRAFFIC_BOTH;
      fill_random(100);
      wait_until_quiet();

      // random registers with junk in the unused bits, long output hold
      write_all({16'($urandom), 16'($urandom)}, {8'($urandom), 24'($urandom_range(40))},
                {16'($urandom), 16'($urandom_range(30))}, 32'h0);
      write_register(REG_TYPE_HIGH,
                     {16'($urandom), 16'(cfg_type_low + $urandom_range(30))});
      traffic_mode = TRAFFIC_HOLD;
      fill_random(130);
      wait_until_quiet();

      // back to the reset values, both sides idling
      write_all(32'(FRAME_VERSION_RST), 32'(MAX_PAYLOAD_RST), 32'(TYPE_LOW_RST),
                32'(TYPE_HIGH_RST));
      traffic_mode = TRAFFIC_BOTH;
      fill_random(140);
      wait_until_quiet();

      if (mismatch_count == 0)
         $display("** frame_header_deframer_core: PASSED **");
      else
         $display("** frame_header_deframer_core: FAILED **");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/fhd_pkg.sv
rtl/core/frame_header_deframer_core.sv
sim/tb_frame_header_deframer_core.sv
